/* rtl/gbcs_pkg.sv */
// gbcs_pkg: types, widths and reset values for the gyro bias/scale/watchdog unit.
// No dependencies; compiled first.
package gbcs_pkg;

  localparam int ADD_W     = 26;                // shared adder width
  localparam int SUM_W     = 25;                // calibration sum
  localparam int MAG_W     = 24;                // dividend magnitude bits
  localparam int REM_W     = 8;                 // divisor / remainder
  localparam int DIV_CNT_W = $clog2(MAG_W);
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] CALIB_COUNT_RST   = 8'd100;
  localparam logic [CFG_W-1:0] STABLE_WINDOW_RST = 8'd1;
  localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RST = 8'd80;

  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_CAL = 2'd0,
    PH_RUN = 2'd1,
    PH_FLT = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CAL_HI,
    ST_CAL_LO,
    ST_CAL_ACC,
    ST_CAL_END,
    ST_ABS,
    ST_DIV,
    ST_NEG,
    ST_RUN_M1,
    ST_RUN_M2,
    ST_RUN_M3,
    ST_DONE
  } seq_state_t;

endpackage

/* rtl/gbcs_in_if.sv */
// gbcs_in_if: input word channel (opcode, raw sample, read status).
// Standalone; valid/ready handshake.
interface gbcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] raw_sample;
  logic               read_ok;

  modport source (output valid, output op, output raw_sample, output read_ok, input ready);
  modport sink   (input valid, input op, input raw_sample, input read_ok, output ready);
endinterface

/* rtl/gbcs_out_if.sv */
// gbcs_out_if: result word channel (scaled rate, status flags, bias).
// Standalone; valid/ready handshake.
interface gbcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] rate_q8;
  logic               fault;
  logic               calibrating;
  logic signed [15:0] bias;

  modport source (output valid, output rate_q8, output fault, output calibrating,
                  output bias, input ready);
  modport sink   (input valid, input rate_q8, input fault, input calibrating,
                  input bias, output ready);
endinterface

/* rtl/gyro_bias_calibrate_scale_watchdog_unit.sv */
// Gyro z-axis bias calibration, Q8 rate scaling and read watchdog.
// Uses gbcs_pkg, gbcs_in_if, gbcs_out_if.
//
// Each input word (sample read, tick or restart) yields exactly one result word
// reporting the held rate, fault, calibrating flag and bias. One word is in work
// at a time; a 26-bit adder is shared by every step under a small sequencer.
// Tick, restart, failed running or faulted reads go from decode straight to result;
// a good running read adds a subtract plus three multiply-by-5 steps; a calibration
// read adds window checks and an accumulate, skipped when the read failed, and the
// last calibration read may add the 24-bit bias division, which runs one quotient bit
// per cycle on the same adder.
// A result waiting in the output register does not block the next accept.
module gyro_bias_calibrate_scale_watchdog_unit
  import gbcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  gbcs_in_if.sink              item,
  gbcs_out_if.source           result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  seq_state_t state, state_next;
  phase_t     phase;

  logic [CFG_W-1:0] calib_count, stable_window, timeout_ticks;

  logic [7:0]        cal_reads;
  logic [REM_W-1:0]  stable_count;
  logic [SUM_W-1:0]  stable_sum;
  logic [15:0]       prev_sample;
  logic [15:0]       offset;
  logic [7:0]        elapsed;
  logic [20:0]       rate_hold;

  logic [1:0]        item_op;
  logic [15:0]       item_raw;
  logic              item_ok;

  logic [ADD_W-1:0]     acc;
  logic                 in_win;
  logic                 neg_q;
  logic [MAG_W-1:0]     dq;
  logic [REM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic               out_valid;
  logic signed [20:0] out_rate;
  logic               out_fault, out_cal;
  logic signed [15:0] out_bias;

  logic [ADD_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;

  logic cal_done, out_free, take;

  assign out_free = !out_valid || result.ready;
  assign take     = item.valid && item.ready;
  assign cal_done = ({1'b0, cal_reads} + 9'd1) >= {1'b0, calib_count};

  // shared adder
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(ADD_W-1){1'b0}}, add_sub};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (take) state_next = ST_DECODE;
      ST_DECODE: begin
        if (item_op == OP_SAMPLE && phase == PH_CAL) begin
          state_next = item_ok ? ST_CAL_HI : ST_CAL_END;
        end else if (item_op == OP_SAMPLE && phase == PH_RUN && item_ok) begin
          state_next = ST_RUN_M1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CAL_HI:  state_next = ST_CAL_LO;
      ST_CAL_LO:  state_next = ST_CAL_ACC;
      ST_CAL_ACC: state_next = ST_CAL_END;
      ST_CAL_END: state_next = (cal_done && stable_count != '0) ? ST_ABS : ST_DONE;
      ST_ABS:     state_next = ST_DIV;
      ST_DIV:     state_next = (div_cnt == '0) ? ST_NEG : ST_DIV;
      ST_NEG:     state_next = ST_DONE;
      ST_RUN_M1:  state_next = ST_RUN_M2;
      ST_RUN_M2:  state_next = ST_RUN_M3;
      ST_RUN_M3:  state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // adder operand selection and handshake outputs
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      ST_DECODE: begin
        add_a   = {{(ADD_W-16){item_raw[15]}}, item_raw};
        add_b   = (phase == PH_CAL) ? {{(ADD_W-16){prev_sample[15]}}, prev_sample}
                                    : {{(ADD_W-16){offset[15]}}, offset};
        add_sub = 1'b1;
      end
      ST_CAL_HI: begin
        add_a   = {{(ADD_W-CFG_W){1'b0}}, stable_window};
        add_b   = acc;
        add_sub = 1'b1;
      end
      ST_CAL_LO: begin
        add_a = acc;
        add_b = {{(ADD_W-CFG_W){1'b0}}, stable_window};
      end
      ST_CAL_ACC: begin
        add_a = {{(ADD_W-SUM_W){stable_sum[SUM_W-1]}}, stable_sum};
        add_b = {{(ADD_W-16){item_raw[15]}}, item_raw};
      end
      ST_ABS: begin
        add_b   = {{(ADD_W-SUM_W){stable_sum[SUM_W-1]}}, stable_sum};
        add_sub = stable_sum[SUM_W-1];
      end
      ST_DIV: begin
        add_a   = {{(ADD_W-REM_W-1){1'b0}}, rem, dq[MAG_W-1]};
        add_b   = {{(ADD_W-REM_W){1'b0}}, stable_count};
        add_sub = 1'b1;
      end
      ST_NEG: begin
        add_b   = {{(ADD_W-MAG_W){1'b0}}, dq};
        add_sub = neg_q;
      end
      ST_RUN_M1, ST_RUN_M2, ST_RUN_M3: begin
        add_a = {acc[ADD_W-3:0], 2'b00};
        add_b = acc;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign item.ready         = (state == ST_IDLE) && !rst;
  assign result.valid       = out_valid;
  assign result.rate_q8     = out_rate;
  assign result.fault       = out_fault;
  assign result.calibrating = out_cal;
  assign result.bias        = out_bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_CAL;
      calib_count   <= CALIB_COUNT_RST;
      stable_window <= STABLE_WINDOW_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
      cal_reads     <= '0;
      stable_count  <= '0;
      stable_sum    <= '0;
      prev_sample   <= '0;
      offset        <= '0;
      elapsed       <= '0;
      rate_hold     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CALIB_COUNT:   calib_count   <= cfg_data;
          CFG_STABLE_WINDOW: stable_window <= cfg_data;
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          default:           ;
        endcase
      end
      if (out_valid && result.ready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take) begin
            item_op  <= item.op;
            item_raw <= item.raw_sample;
            item_ok  <= item.read_ok;
          end
        end
        ST_DECODE: begin
          acc <= add_sum;
          case (item_op)
            OP_SAMPLE: begin
              if (phase == PH_RUN) begin
                if (item_ok) begin
                  elapsed <= '0;
                end else if (elapsed > timeout_ticks) begin
                  rate_hold <= '0;
                  phase     <= PH_FLT;
                end
              end
            end
            OP_TICK:    if (elapsed != '1) elapsed <= elapsed + 8'd1;
            OP_RESTART: begin
              if (phase == PH_FLT) begin
                phase     <= PH_RUN;
                elapsed   <= '0;
                rate_hold <= '0;
              end else if (phase == PH_RUN) begin
                elapsed <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_CAL_HI: in_win <= !add_sum[ADD_W-1];
        ST_CAL_LO: in_win <= in_win && !add_sum[ADD_W-1];
        ST_CAL_ACC: begin
          if (in_win) begin
            stable_sum   <= add_sum[SUM_W-1:0];
            stable_count <= stable_count + 1'b1;
          end
          prev_sample <= item_raw;
        end
        ST_CAL_END: begin
          cal_reads <= cal_reads + 8'd1;
          if (cal_done) begin
            phase     <= PH_RUN;
            elapsed   <= '0;
            rate_hold <= '0;
            neg_q     <= stable_sum[SUM_W-1];
            if (stable_count == '0) offset <= '0;
          end
        end
        ST_ABS: begin
          dq      <= add_sum[MAG_W-1:0];
          rem     <= '0;
          div_cnt <= DIV_CNT_W'(MAG_W - 1);
        end
        ST_DIV: begin
          if (!add_sum[ADD_W-1]) begin
            rem <= add_sum[REM_W-1:0];
            dq  <= {dq[MAG_W-2:0], 1'b1};
          end else begin
            rem <= {rem[REM_W-2:0], dq[MAG_W-1]};
            dq  <= {dq[MAG_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - 1'b1;
        end
        ST_NEG:    offset <= add_sum[15:0];
        ST_RUN_M1: acc <= add_sum;
        ST_RUN_M2: acc <= add_sum;
        ST_RUN_M3: rate_hold <= add_sum[23:3];
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_rate  <= (phase == PH_RUN) ? rate_hold : '0;
            out_fault <= (phase == PH_FLT);
            out_cal   <= (phase == PH_CAL);
            out_bias  <= offset;
          end
        end
        default: ;
      endcase
    end
  end

  // remainder always stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < stable_count)
    else $error("division remainder out of range");

  // no rate reported unless running
  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_fault || out_cal) |-> out_rate == '0)
    else $error("rate reported while calibrating or faulted");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_fault && out_cal))
    else $error("fault and calibrating both set");

  // calibration sum frozen once calibration is over
  a_sum_frozen: assert property (@(posedge clk) disable iff (rst)
    phase != PH_CAL |=> $stable(stable_sum))
    else $error("calibration sum changed after calibration");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !item.ready)
    else $error("accepted a word while busy");

endmodule

/* tb/sv/gyro_status_checker.sv */
`timescale 1ns / 100ps
// gyro_status_checker: tracks the gyro unit's calibration, scaling and watchdog state from the
// accepted input words and register writes, and compares every result word against it.
// Uses gbcs_pkg, gbcs_in_if and gbcs_out_if.
module gyro_status_checker
  import gbcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  gbcs_in_if                   item,
  gbcs_out_if                  result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   words_checked
);

  typedef struct {
    logic signed [20:0] rate_q8;
    logic               fault;
    logic               calibrating;
    logic signed [15:0] bias;
  } gyro_status_t;

  gyro_status_t status_q[$];

  logic [CFG_W-1:0]   calib_count;
  logic [CFG_W-1:0]   stable_window;
  logic [CFG_W-1:0]   timeout_ticks;

  phase_t             phase;
  int                 cal_reads;
  int                 stable_cnt;
  int                 stable_sum;
  int                 prev_raw;
  int                 bias_val;
  int                 elapsed;
  logic signed [20:0] rate_hold;
  int                 err_cnt;
  int                 checked_cnt;

  task automatic advance_gyro(input logic [1:0] op, input logic signed [15:0] raw,
                              input logic ok);
    int           diff;
    int           scaled;
    gyro_status_t st;
    case (op)
      OP_SAMPLE: begin
        if (phase == PH_CAL) begin
          if (ok) begin
            diff = int'(raw) - prev_raw;
            if (diff <= int'(stable_window) && diff >= -int'(stable_window)) begin
              stable_cnt++;
              stable_sum += int'(raw);
            end
            prev_raw = int'(raw);
          end
          cal_reads++;
          if (cal_reads >= int'(calib_count)) begin
            bias_val  = (stable_cnt != 0) ? stable_sum / stable_cnt : 0;
            phase     = PH_RUN;
            elapsed   = 0;
            rate_hold = '0;
          end
        end else if (phase == PH_RUN) begin
          if (ok) begin
            elapsed   = 0;
            scaled    = (int'(raw) - bias_val) * 125;
            rate_hold = 21'(scaled >>> 3);
          end else if (elapsed > int'(timeout_ticks)) begin
            rate_hold = '0;
            phase     = PH_FLT;
          end
        end
      end
      OP_TICK: begin
        if (elapsed < 255) elapsed++;
      end
      OP_RESTART: begin
        if (phase == PH_FLT) begin
          phase     = PH_RUN;
          elapsed   = 0;
          rate_hold = '0;
        end else if (phase == PH_RUN) begin
          elapsed = 0;
        end
      end
      default: ;
    endcase
    st.rate_q8     = (phase == PH_RUN) ? rate_hold : '0;
    st.fault       = (phase == PH_FLT);
    st.calibrating = (phase == PH_CAL);
    st.bias        = 16'(bias_val);
    status_q.push_back(st);
  endtask

  task automatic compare_status();
    gyro_status_t want;
    if (status_q.size() == 0) begin
      $error("result word with no expectation pending");
      err_cnt++;
    end else begin
      want = status_q.pop_front();
      checked_cnt++;
      if (result.rate_q8 !== want.rate_q8) begin
        $error("rate_q8: expected %0d, got %0d", want.rate_q8, result.rate_q8);
        err_cnt++;
      end
      if (result.fault !== want.fault) begin
        $error("fault: expected %0b, got %0b", want.fault, result.fault);
        err_cnt++;
      end
      if (result.calibrating !== want.calibrating) begin
        $error("calibrating: expected %0b, got %0b", want.calibrating, result.calibrating);
        err_cnt++;
      end
      if (result.bias !== want.bias) begin
        $error("bias: expected %0d, got %0d", want.bias, result.bias);
        err_cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      calib_count   = CALIB_COUNT_RST;
      stable_window = STABLE_WINDOW_RST;
      timeout_ticks = TIMEOUT_TICKS_RST;
      phase         = PH_CAL;
      cal_reads     = 0;
      stable_cnt    = 0;
      stable_sum    = 0;
      prev_raw      = 0;
      bias_val      = 0;
      elapsed       = 0;
      rate_hold     = '0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CALIB_COUNT:   calib_count   = cfg_data;
          CFG_STABLE_WINDOW: stable_window = cfg_data;
          CFG_TIMEOUT_TICKS: timeout_ticks = cfg_data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) advance_gyro(item.op, item.raw_sample, item.read_ok);
      if (result.valid && result.ready) compare_status();
    end
    mismatches    <= err_cnt;
    outstanding   <= status_q.size();
    words_checked <= checked_cnt;
  end

endmodule

/* tb/sv/tb_gyro_bias_calibrate_scale_watchdog_unit.sv */
`timescale 1ns / 100ps
// tb_gyro_bias_calibrate_scale_watchdog_unit: stimulus and verdict for the gyro unit.
// Drives calibration, running and watchdog traffic with bursty sends and sink stalls;
// checking is done by gyro_status_checker. Uses gbcs_pkg and both channel interfaces.
module tb_gyro_bias_calibrate_scale_watchdog_unit;
  import gbcs_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         TIMEOUT_NS = 20_000_000;
  localparam int         PHASES     = 8;
  localparam int         PHASE_WORDS = 150;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_CALIB_COUNT;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 result_ready = 1'b0;

  int mismatches;
  int outstanding;
  int words_checked;
  int words_sent     = 0;
  int settings_used  = 0;
  int burst_left     = 0;
  int stall_left     = 0;
  int sink_mode      = 0;
  int sink_cycle     = 0;
  int cal_mode;
  logic signed [15:0] cal_level;
  logic signed [15:0] last_cal_raw = '0;

  gbcs_in_if  item();
  gbcs_out_if result();

  assign result.ready = result_ready;

  always #6 clk = ~clk;

  gyro_bias_calibrate_scale_watchdog_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gyro_status_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  // sink: no stalls, short random stalls, or rare long stalls, in a mode re-drawn at random
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle % 400 == 0) sink_mode <= $urandom_range(0, 2);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (sink_mode == 1 && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        stall_left   <= $urandom_range(0, 4);
      end else if (sink_mode == 2 && $urandom_range(0, 15) == 0) begin
        result_ready <= 1'b0;
        stall_left   <= $urandom_range(5, 30);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic signed [15:0] raw, input logic ok);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.valid      <= 1'b1;
    item.op         <= op;
    item.raw_sample <= raw;
    item.read_ok    <= ok;
    do @(posedge clk); while (!item.ready);
    words_sent++;
  endtask

  task automatic drain_results();
    item.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] cc, input logic [CFG_W-1:0] sw,
                                input logic [CFG_W-1:0] tt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CALIB_COUNT;
    cfg_data  <= cc;
    @(posedge clk);
    cfg_index <= CFG_STABLE_WINDOW;
    cfg_data  <= sw;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= tt;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // calibration read; the no-stable style swings between the rails on every good read
  task automatic cal_read(input logic ok, input int jit);
    logic signed [15:0] raw;
    if (cal_mode == 3) raw = (last_cal_raw < 0) ? 16'(32767 - jit) : 16'(-32768 + jit);
    else if (cal_mode == 0) raw = 16'(32767 - jit);
    else raw = 16'(int'(cal_level) + jit);
    if (!ok) raw = 16'($urandom);
    send_word(OP_SAMPLE, raw, ok);
    if (ok) last_cal_raw = raw;
  endtask

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_timeout(input int p);
    case (p)
      0:       return 8'd0;
      1:       return 8'd3;
      2:       return 8'd254;
      3:       return 8'd255;
      4:       return 8'd0;
      5:       return 8'($urandom_range(4, 90));
      default: return 8'($urandom_range(1, 30));
    endcase
  endfunction

  task automatic watchdog_episode(input logic [CFG_W-1:0] tt);
    int n;
    n = int'(tt) + $urandom_range(0, 3) - 1;
    if (n < 0) n = 0;
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) send_word(OP_SAMPLE, pick_raw(), 1'b0);
      else send_word(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
    end
    send_word(OP_SAMPLE, pick_raw(), 1'b0);
    if ($urandom_range(0, 1)) send_word(OP_SAMPLE, pick_raw(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) send_word(OP_TICK, pick_raw(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) != 0) send_word(OP_RESTART, pick_raw(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int                 k;
    int                 phase_start;
    logic [CFG_W-1:0]   tt;
    item.valid      = 1'b0;
    item.op         = OP_TICK;
    item.raw_sample = '0;
    item.read_ok    = 1'b0;
    cal_mode  = $urandom_range(0, 3);
    cal_level = (cal_mode == 1) ? 16'sh8000 : 16'($urandom_range(0, 60000) - 30000);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // calibration with an exact-match window and no watchdog margin
    write_settings(8'd255, 8'd0, 8'd0);
    send_word(OP_UNUSED, 16'sh7fff, 1'b1);
    send_word(OP_RESTART, 16'sh0000, 1'b0);
    send_word(OP_TICK, 16'sh8000, 1'b1);
    send_word(OP_SAMPLE, 16'sh7fff, 1'b0);
    for (k = 0; k < 6; k++) cal_read(1'b1, 0);
    cal_read(1'b0, 0);
    cal_read(1'b1, 0);
    drain_results();

    write_settings(8'd255, 8'($urandom_range(1, 8)), 8'd0);
    for (k = 0; k < 40; k++) begin
      case ($urandom_range(0, 11))
        0:       send_word(OP_TICK, pick_raw(), 1'($urandom_range(0, 1)));
        1:       send_word(OP_RESTART, pick_raw(), 1'($urandom_range(0, 1)));
        2:       send_word(OP_UNUSED, pick_raw(), 1'($urandom_range(0, 1)));
        default: cal_read($urandom_range(0, 9) != 0, $urandom_range(0, 4));
      endcase
    end
    drain_results();

    // zero read count closes calibration on the next read
    write_settings(8'd0, 8'd255, 8'd255);
    cal_read(cal_mode != 3, 0);
    send_word(OP_SAMPLE, 16'sh7fff, 1'b1);
    send_word(OP_SAMPLE, 16'sh8000, 1'b1);
    send_word(OP_SAMPLE, 16'sh0000, 1'b1);
    send_word(OP_SAMPLE, 16'shffff, 1'b1);
    repeat (3) send_word(OP_TICK, 16'sh0000, 1'b0);
    send_word(OP_SAMPLE, 16'sh5555, 1'b0);
    send_word(OP_RESTART, 16'shaaaa, 1'b1);
    send_word(OP_UNUSED, 16'sh8000, 1'b0);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      tt = pick_timeout(p);
      write_settings((p % 2 == 0) ? 8'd255 : 8'($urandom),
                     (p % 3 == 0) ? 8'd0 : 8'($urandom), tt);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        k = $urandom_range(0, 9);
        if (k < 4) begin
          repeat ($urandom_range(1, 6)) send_word(OP_SAMPLE, pick_raw(), 1'b1);
        end else if (k < 7) begin
          watchdog_episode(tt);
        end else begin
          repeat ($urandom_range(1, 6))
            send_word(2'($urandom_range(0, 3)), pick_raw(), 1'($urandom_range(0, 1)));
        end
      end
      drain_results();
    end

    $display("Covered %0d input words over %0d register settings, calibration style %0d.",
             words_sent, settings_used, cal_mode);
    $display("%0d result words compared, %0d still awaited.", words_checked, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d result words awaited.", outstanding);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
rtl/gbcs_pkg.sv
rtl/gbcs_in_if.sv
rtl/gbcs_out_if.sv
rtl/gyro_bias_calibrate_scale_watchdog_unit.sv
tb/sv/gyro_status_checker.sv
tb/sv/tb_gyro_bias_calibrate_scale_watchdog_unit.sv
